// ===== design/w3r_pkg.sv =====
// Shared types, constants and a helper function for the WENO3 face reconstruction unit.
// Depends on nothing; every other design file but the checker refers to it by scoped names.

package w3r_pkg;

	// Reset value of the regularizer, about 1e-6 in unsigned Q0.32.
	localparam logic [31:0] EPS_RESET = 32'd4295;

	// Linear weight floor(2^31/3), used when both regularized indicators are zero.
	localparam logic [31:0] LIN_W0 = 32'd715827882;

	// Number of pipeline stages in the nonlinear weight path.
	localparam int WEIGHT_LAT = 42;

	// Number of restoring division steps after the leading quotient bit.
	localparam int DIV_STEPS = 31;

	// Status of the word queue between the front and back parts.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Bit length of a 16-bit chunk (zero for an all-zero chunk).
	function automatic logic [4:0] bitlen16(input logic [15:0] x);
		logic [4:0] r;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			if (x[i]) begin
				r = 5'(i + 1);
			end
		end
		return r;
	endfunction

endpackage

// ===== design/w3r_queue.sv =====
// Small register FIFO that decouples the front part from the back part.
// Depends on w3r_pkg for the status struct.

module w3r_queue #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     push_data,
	input  logic                 pop,
	output logic [WIDTH-1:0]     head,
	output w3r_pkg::q_status_t   status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	// A push is refused while full; a pop is refused while empty.
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	// Storage for queued words; no reset needed.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== design/w3r_front.sv =====
// Front part: accepts words, picks the upwind stencil and forms differences.
// Depends on w3r_pkg for the queue status struct.

module w3r_front #(
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] cell_left,
	input  logic signed [SAMPLE_WIDTH-1:0] cell_center,
	input  logic signed [SAMPLE_WIDTH-1:0] cell_right,
	input  logic signed [SAMPLE_WIDTH-1:0] cell_far_right,
	input  logic                           direction,
	input  w3r_pkg::q_status_t             q_status,
	output logic                           push,
	output logic [4*SAMPLE_WIDTH+4:0]      push_data
);

	localparam int W  = SAMPLE_WIDTH;
	localparam int DW = W + 1;
	localparam int FW = W + 2;

	logic                 fen;
	logic                 valid_s1;
	logic                 valid_s2;
	logic signed [DW-1:0] d0_s1;
	logic signed [DW-1:0] d1_s1;
	logic signed [DW-1:0] h1_s1;
	logic [DW-1:0]        m0_s2;
	logic [DW-1:0]        m1_s2;
	logic signed [FW-1:0] dif_s2;
	logic signed [DW-1:0] h1_s2;
	logic signed [W-1:0]  sa;
	logic signed [W-1:0]  sb;
	logic signed [W-1:0]  sc;

	// The front advances unless its last stage holds a word the queue cannot take.
	assign fen      = !(valid_s2 && q_status.full);
	assign in_stall = !fen;
	assign push     = valid_s2;
	assign push_data = {h1_s2, dif_s2, m1_s2, m0_s2};

	// Stencil selection: mirrored for negative upwinding.
	always_comb begin
		if (direction) begin
			sa = cell_far_right;
			sb = cell_right;
			sc = cell_center;
		end else begin
			sa = cell_left;
			sb = cell_center;
			sc = cell_right;
		end
	end

	// Valid bits of the two front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (fen) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage one forms the stencil differences and the right candidate sum.
	// Stage two takes magnitudes and the candidate difference 2b - a - c.
	always_ff @(posedge clk) begin
		if (fen) begin
			d0_s1  <= DW'(sa) - DW'(sb);
			d1_s1  <= DW'(sb) - DW'(sc);
			h1_s1  <= DW'(sb) + DW'(sc);
			m0_s2  <= d0_s1[DW-1] ? DW'(-d0_s1) : DW'(d0_s1);
			m1_s2  <= d1_s1[DW-1] ? DW'(-d1_s1) : DW'(d1_s1);
			dif_s2 <= FW'(d1_s1) - FW'(d0_s1);
			h1_s2  <= h1_s1;
		end
	end

endmodule

// ===== design/w3r_weight.sv =====
// Nonlinear weight path: indicators, normalization, powers and a pipelined divider.
// Depends on w3r_pkg for constants and the chunk bit-length helper.

module w3r_weight #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int WEIGHT_POWER = 2
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [SAMPLE_WIDTH:0]   mag0,
	input  logic [SAMPLE_WIDTH:0]   mag1,
	input  logic [31:0]             epsilon,
	output logic [31:0]             w0
);

	localparam int NS = w3r_pkg::DIV_STEPS;

	logic [63:0] sq0_s1, sq1_s1;
	logic [63:0] d0_s2, d1_s2;
	logic [63:0] d0_s3, d1_s3, mx_s3;
	logic [63:0] d0_s4, d1_s4;
	logic [4:0]  hb_s4 [4];
	logic [3:0]  nz_s4;
	logic [30:0] e0_s5, e1_s5;
	logic [63:0] p0_s6, p1_s6;
	logic [63:0] n0_s7, t_s7;
	logic        zero_s7;
	logic [63:0] n0_s8, t_s8;
	logic        zero_s8;
	logic [4:0]  hbt_s8 [4];
	logic [3:0]  nzt_s8;
	logic [31:0] n0_s9, t_s9;
	logic        zero_s9;
	logic [31:0] rem_s [NS+1];
	logic [31:0] quo_s [NS+1];
	logic [31:0] den_s [NS+1];
	logic        zro_s [NS+1];
	logic [63:0] m0x, m1x;
	logic [64:0] sum0, sum1;
	logic [6:0]  bl_mx, bl_t;
	logic [5:0]  sft, sht;
	logic [61:0] sqe0, sqe1;

	assign m0x = 64'(mag0);
	assign m1x = 64'(mag1);
	assign sum0 = {1'b0, sq0_s1} + 65'(epsilon);
	assign sum1 = {1'b0, sq1_s1} + 65'(epsilon);
	assign sqe0 = {31'b0, e0_s5} * {31'b0, e0_s5};
	assign sqe1 = {31'b0, e1_s5} * {31'b0, e1_s5};

	// Bit lengths of the wider indicator and of the weight denominator.
	always_comb begin
		bl_mx = '0;
		bl_t  = '0;
		for (int c = 0; c < 4; c++) begin
			if (nz_s4[c]) begin
				bl_mx = 7'(16 * c) + 7'(hb_s4[c]);
			end
			if (nzt_s8[c]) begin
				bl_t = 7'(16 * c) + 7'(hbt_s8[c]);
			end
		end
		sft = (bl_mx > 7'd31) ? 6'(bl_mx - 7'd31) : '0;
		sht = (bl_t > 7'd32) ? 6'(bl_t - 7'd32) : '0;
	end

	// Stages one to nine: squares, regularization, normalization and powers.
	always_ff @(posedge clk) begin
		if (en) begin
			sq0_s1 <= (|m0x[63:32]) ? '1 : 64'(m0x[31:0]) * 64'(m0x[31:0]);
			sq1_s1 <= (|m1x[63:32]) ? '1 : 64'(m1x[31:0]) * 64'(m1x[31:0]);
			d0_s2  <= sum0[64] ? '1 : sum0[63:0];
			d1_s2  <= sum1[64] ? '1 : sum1[63:0];
			d0_s3  <= d0_s2;
			d1_s3  <= d1_s2;
			mx_s3  <= (d0_s2 > d1_s2) ? d0_s2 : d1_s2;
			d0_s4  <= d0_s3;
			d1_s4  <= d1_s3;
			for (int c = 0; c < 4; c++) begin
				hb_s4[c] <= w3r_pkg::bitlen16(mx_s3[16*c +: 16]);
				nz_s4[c] <= |mx_s3[16*c +: 16];
			end
			e0_s5  <= 31'(d0_s4 >> sft);
			e1_s5  <= 31'(d1_s4 >> sft);
			p0_s6  <= (WEIGHT_POWER == 2) ? 64'(sqe0) : 64'(e0_s5);
			p1_s6  <= (WEIGHT_POWER == 2) ? 64'(sqe1) : 64'(e1_s5);
			n0_s7  <= p1_s6;
			t_s7   <= p1_s6 + {p0_s6[62:0], 1'b0};
			zero_s7 <= (p0_s6 == '0) && (p1_s6 == '0);
			n0_s8  <= n0_s7;
			t_s8   <= t_s7;
			zero_s8 <= zero_s7;
			for (int c = 0; c < 4; c++) begin
				hbt_s8[c] <= w3r_pkg::bitlen16(t_s7[16*c +: 16]);
				nzt_s8[c] <= |t_s7[16*c +: 16];
			end
			n0_s9  <= 32'(n0_s8 >> sht);
			t_s9   <= 32'(t_s8 >> sht);
			zero_s9 <= zero_s8;
		end
	end

	// Divider setup: the leading quotient bit is set only when n0 equals T.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= (n0_s9 >= t_s9) ? n0_s9 - t_s9 : n0_s9;
			quo_s[0] <= {(n0_s9 >= t_s9), 31'b0};
			den_s[0] <= t_s9;
			zro_s[0] <= zero_s9;
		end
	end

	// One restoring division step per stage, one quotient bit each.
	for (genvar k = 1; k <= NS; k++) begin : g_div
		logic [32:0] rem2;
		logic        ge;
		assign rem2 = {rem_s[k-1], 1'b0};
		assign ge   = (rem2 >= {1'b0, den_s[k-1]});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? 32'(rem2 - {1'b0, den_s[k-1]}) : 32'(rem2);
				quo_s[k] <= quo_s[k-1] | (ge ? (32'd1 << (NS - k)) : 32'd0);
				den_s[k] <= den_s[k-1];
				zro_s[k] <= zro_s[k-1];
			end
		end
	end

	// Final weight; a flat regularized stencil takes the linear weight.
	always_ff @(posedge clk) begin
		if (en) begin
			w0 <= zro_s[NS] ? w3r_pkg::LIN_W0 : quo_s[NS];
		end
	end

endmodule

// ===== design/w3r_back.sv =====
// Back part: takes words off the queue, weights the candidates and drives the result.
// Depends on w3r_pkg and instantiates w3r_weight.

module w3r_back #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int WEIGHT_POWER = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [4*SAMPLE_WIDTH+4:0]      head,
	input  w3r_pkg::q_status_t             q_status,
	output logic                           pop,
	input  logic [31:0]                    epsilon,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] face_value,
	output logic                           saturated
);

	localparam int W   = SAMPLE_WIDTH;
	localparam int DW  = W + 1;
	localparam int FW  = W + 2;
	localparam int ZW  = W + 4;
	localparam int WL  = w3r_pkg::WEIGHT_LAT;
	localparam int TOT = WL + 4;
	localparam int CW  = DW + FW;
	localparam logic signed [ZW-1:0] HI = ZW'((64'd1 << (W - 1)) - 64'd1);
	localparam logic signed [ZW-1:0] LO = -HI - ZW'(1);

	logic                 en;
	logic                 vld_s [TOT];
	logic [CW-1:0]        carry_s [WL];
	logic [31:0]          w0;
	logic [DW-1:0]        m0;
	logic [DW-1:0]        m1;
	logic signed [DW-1:0] h1_c;
	logic signed [FW-1:0] dif_c;
	logic [63:0]          mag_s43;
	logic                 neg_s43, neg_s44, neg_s45;
	logic [31:0]          w_s43;
	logic signed [DW-1:0] h1_s43, h1_s44, h1_s45;
	logic [63:0]          plo_s44, phi_s44;
	logic [FW-1:0]        r_s45;
	logic [96:0]          psum;
	logic signed [ZW-1:0] rx, z, y;

	// The whole back pipeline moves unless the result register is held.
	assign en        = !(vld_s[TOT-1] && out_stall);
	assign pop       = en && !q_status.empty;
	assign out_valid = vld_s[TOT-1];
	assign m0        = head[DW-1:0];
	assign m1        = head[2*DW-1:DW];
	assign {h1_c, dif_c} = carry_s[WL-1];

	w3r_weight #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.WEIGHT_POWER (WEIGHT_POWER)
	) u_weight (
		.clk     (clk),
		.en      (en),
		.mag0    (m0),
		.mag1    (m1),
		.epsilon (epsilon),
		.w0      (w0)
	);

	// Valid bits follow the words down the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TOT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= !q_status.empty;
			for (int k = 1; k < TOT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Candidate terms ride alongside the weight path.
	always_ff @(posedge clk) begin
		if (en) begin
			carry_s[0] <= head[4*W+4:2*DW];
			for (int k = 1; k < WL; k++) begin
				carry_s[k] <= carry_s[k-1];
			end
		end
	end

	assign psum = {1'b0, phi_s44, 32'b0} + {33'b0, plo_s44} + (97'd1 << 30);
	assign rx   = signed'(ZW'(r_s45));
	assign z    = ZW'(h1_s45) + (neg_s45 ? -rx : rx) + ZW'(1);
	assign y    = z >>> 1;

	// Blend: magnitude, split product, rounding, then halving and clipping.
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s43    <= 64'(dif_c[FW-1] ? FW'(-dif_c) : FW'(dif_c));
			neg_s43    <= dif_c[FW-1];
			w_s43      <= w0;
			h1_s43     <= h1_c;
			plo_s44    <= 64'(mag_s43[31:0]) * 64'(w_s43);
			phi_s44    <= 64'(mag_s43[63:32]) * 64'(w_s43);
			neg_s44    <= neg_s43;
			h1_s44     <= h1_s43;
			r_s45      <= FW'(psum >> 31);
			neg_s45    <= neg_s44;
			h1_s45     <= h1_s44;
			if (y > HI) begin
				face_value <= W'(HI);
				saturated  <= 1'b1;
			end else if (y < LO) begin
				face_value <= W'(LO);
				saturated  <= 1'b1;
			end else begin
				face_value <= W'(y);
				saturated  <= 1'b0;
			end
		end
	end

endmodule

// ===== design/weno3_face_reconstruction_unit.sv =====
// Top level of the WENO3 face reconstruction unit: front, queue and back parts.
// Depends on w3r_pkg, w3r_front, w3r_queue and w3r_back.
//
//   Channel | Handshake            | Words
//   input   | in_valid / in_stall  | cell_left, cell_center, cell_right, cell_far_right, direction
//   output  | out_valid / out_stall| face_value, saturated
//   config  | cfg_valid / cfg_ready| epsilon
//
// One word is accepted per cycle unless in_stall is high; a result passes the front
// stages, the queue and the back pipeline, mostly the 31-step pipelined divider
// of the weight path. Reset clears all valid bits, the queue and restores epsilon.
// A held output stalls the back part; the queue of four words then absorbs the
// front part before in_stall rises. Configuration writes are always taken.

module weno3_face_reconstruction_unit #(
	parameter int WEIGHT_POWER = 2,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] cell_left,
	input  logic signed [SAMPLE_WIDTH-1:0] cell_center,
	input  logic signed [SAMPLE_WIDTH-1:0] cell_right,
	input  logic signed [SAMPLE_WIDTH-1:0] cell_far_right,
	input  logic                           direction,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] face_value,
	output logic                           saturated,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [31:0]                    epsilon
);

	localparam int QW = 4 * SAMPLE_WIDTH + 5;

	logic               push;
	logic               pop;
	logic [QW-1:0]      push_data;
	logic [QW-1:0]      head;
	logic [31:0]        epsilon_q;
	w3r_pkg::q_status_t q_status;

	assign cfg_ready = 1'b1;

	// Regularizer register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q <= w3r_pkg::EPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			epsilon_q <= epsilon;
		end
	end

	w3r_front #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cell_left      (cell_left),
		.cell_center    (cell_center),
		.cell_right     (cell_right),
		.cell_far_right (cell_far_right),
		.direction      (direction),
		.q_status       (q_status),
		.push           (push),
		.push_data      (push_data)
	);

	w3r_queue #(
		.WIDTH (QW),
		.DEPTH (4)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	w3r_back #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.WEIGHT_POWER (WEIGHT_POWER)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_status   (q_status),
		.pop        (pop),
		.epsilon    (epsilon_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.face_value (face_value),
		.saturated  (saturated)
	);

endmodule

// ===== design/w3r_checker.sv =====
// Port-level checker for the WENO3 face reconstruction unit, bound to the top level.
// Depends only on the top level's ports.

module w3r_checker #(
	parameter int WEIGHT_POWER = 2,
	parameter int SAMPLE_WIDTH = 32
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [SAMPLE_WIDTH-1:0] face_value,
	input logic                    saturated,
	input logic                    cfg_valid,
	input logic                    cfg_ready
);

	localparam logic [SAMPLE_WIDTH-1:0] MAXV = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic [SAMPLE_WIDTH-1:0] MINV = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	// A held result word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(face_value))
		else $error("result word changed while held");

	// A clipped result sits exactly on one end of the sample range.
	a_sat_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> face_value == MAXV || face_value == MINV)
		else $error("saturated result not at a range limit");

	// The input side only backs up after the output side was held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stalled without a held result");

	// Configuration words are never refused.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration word refused");

endmodule

bind weno3_face_reconstruction_unit w3r_checker #(
	.WEIGHT_POWER (WEIGHT_POWER),
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_w3r_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.face_value (face_value),
	.saturated  (saturated),
	.cfg_valid  (cfg_valid),
	.cfg_ready  (cfg_ready)
);
